[sv/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
// Holds the scan word, query and cell write types, plus mode, status and
// register codes. No dependencies.
package ffha_pkg;

  // Slot index width covers the largest supported block table.
  localparam int unsigned IDX_W = 10;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned HDR_W = 7;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Request modes carried in the input tuser.
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE = 2'd1;
  localparam logic [1:0] MODE_REALLOC = 2'd2;
  localparam logic [1:0] MODE_CALLOC = 2'd3;

  // Result status codes.
  localparam logic [2:0] STAT_OK = 3'd0;
  localparam logic [2:0] STAT_NO_HEAP = 3'd1;
  localparam logic [2:0] STAT_NULL = 3'd2;
  localparam logic [2:0] STAT_UNKNOWN = 3'd3;
  localparam logic [2:0] STAT_FULL = 3'd4;
  localparam logic [2:0] STAT_OVERFLOW = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_HDR = 2'd2;

  // Register reset values.
  localparam addr_t BASE_RESET = 32'd4096;
  localparam addr_t LIMIT_RESET = 32'hFFFF_FFFF;
  localparam logic [HDR_W-1:0] HDR_RESET = 7'd16;

  // Word that travels down the row of cells during one scan.
  typedef struct packed {
    logic  valid;
    logic  find_hit;
    idx_t  find_idx;
    addr_t find_size;
    logic  fit_hit;
    idx_t  fit_idx;
    addr_t fit_start;
    logic  empty_hit;
    idx_t  empty_idx;
    logic  left_hit;
    idx_t  left_idx;
    addr_t left_size;
    logic  right_hit;
    idx_t  right_idx;
    addr_t right_size;
  } scan_word_t;

  // Query broadcast to every cell while a scan runs.
  typedef struct packed {
    addr_t             addr;
    addr_t             fit_size;
    logic [HDR_W-1:0]  hdr;
    logic [ADDR_W:0]   end_s;
  } scan_query_t;

  // Write command to one cell, selected by index.
  typedef struct packed {
    logic  we;
    idx_t  idx;
    logic  used;
    logic  is_free;
    logic  start_we;
    addr_t start;
    logic  size_we;
    addr_t size;
  } cell_wr_t;

endpackage

[sv/ffha_cell.sv]
// One slot of the block table with its scan stage.
// Depends on ffha_pkg for the scan word, query and write types.
module ffha_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffha_pkg::scan_query_t query_i,
  input  ffha_pkg::cell_wr_t  wr_i,
  input  ffha_pkg::scan_word_t word_i,
  output ffha_pkg::scan_word_t word_o,
  output logic                used_o
);

  localparam ffha_pkg::idx_t MyIdx = ffha_pkg::IDX_W'(IDX);

  ffha_pkg::addr_t start_q, size_q;
  logic used_q, free_q;
  ffha_pkg::scan_word_t word_d, word_q;
  logic sel;
  logic [ffha_pkg::ADDR_W:0] pay;
  logic [ffha_pkg::ADDR_W+1:0] end_hdr;
  logic live_free, m_find, m_fit, m_left, m_right;

  assign sel = wr_i.we && (wr_i.idx == MyIdx);

  // Slot flags are cleared at reset; start and size are valid only when used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      free_q <= 1'b0;
    end else if (sel) begin
      used_q <= wr_i.used;
      free_q <= wr_i.is_free;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && wr_i.start_we) begin
      start_q <= wr_i.start;
    end
    if (sel && wr_i.size_we) begin
      size_q <= wr_i.size;
    end
  end

  // Compare this slot against the query.
  always_comb begin
    pay = {1'b0, start_q} + {{(ffha_pkg::ADDR_W + 1 - ffha_pkg::HDR_W){1'b0}}, query_i.hdr};
    end_hdr = {2'b00, start_q} + {2'b00, size_q}
            + {{(ffha_pkg::ADDR_W + 2 - ffha_pkg::HDR_W){1'b0}}, query_i.hdr}
            + {{(ffha_pkg::ADDR_W + 2 - ffha_pkg::HDR_W){1'b0}}, query_i.hdr};
    live_free = used_q && free_q;
    m_find = used_q && !free_q && (pay == {1'b0, query_i.addr});
    m_fit = live_free && (size_q >= query_i.fit_size)
          && (!word_i.fit_hit || (start_q < word_i.fit_start));
    m_left = live_free && (end_hdr == {2'b00, query_i.addr});
    m_right = live_free && ({1'b0, start_q} == query_i.end_s);

    word_d = word_i;
    if (!word_i.find_hit && m_find) begin
      word_d.find_hit = 1'b1;
      word_d.find_idx = MyIdx;
      word_d.find_size = size_q;
    end
    if (m_fit) begin
      word_d.fit_hit = 1'b1;
      word_d.fit_idx = MyIdx;
      word_d.fit_start = start_q;
    end
    if (!word_i.empty_hit && !used_q) begin
      word_d.empty_hit = 1'b1;
      word_d.empty_idx = MyIdx;
    end
    if (!word_i.left_hit && m_left) begin
      word_d.left_hit = 1'b1;
      word_d.left_idx = MyIdx;
      word_d.left_size = size_q;
    end
    if (!word_i.right_hit && m_right) begin
      word_d.right_hit = 1'b1;
      word_d.right_idx = MyIdx;
      word_d.right_size = size_q;
    end
  end

  // Hand the word to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;
  assign used_o = used_q;

endmodule

[sv/ffha_ctrl.sv]
// Request sequencer of the allocator: decodes a word, runs the table scans,
// issues slot writes and holds the break pointer and the result register.
// Depends on ffha_pkg.
module ffha_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             in_mode_i,
  input  ffha_pkg::addr_t        in_addr_i,
  input  ffha_pkg::addr_t        in_size_i,
  input  ffha_pkg::addr_t        in_count_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [127:0]           out_data_o,
  output logic [2:0]             out_status_o,
  input  logic [ffha_pkg::HDR_W-1:0] hdr_i,
  input  ffha_pkg::addr_t        limit_i,
  input  logic                   base_load_i,
  input  ffha_pkg::addr_t        base_i,
  output ffha_pkg::scan_query_t  query_o,
  output logic                   start_o,
  input  ffha_pkg::scan_word_t   tail_i,
  output ffha_pkg::cell_wr_t     wr_o
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_MUL    = 14'b00000000000010,
    S_DECIDE = 14'b00000000000100,
    S_PASSA  = 14'b00000000001000,
    S_EVALA  = 14'b00000000010000,
    S_PASSB  = 14'b00000000100000,
    S_EVALB  = 14'b00000001000000,
    S_WALLOC = 14'b00000010000000,
    S_SUM1   = 14'b00000100000000,
    S_SUM2   = 14'b00001000000000,
    S_WT     = 14'b00010000000000,
    S_WS     = 14'b00100000000000,
    S_WR     = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REALLOC
  } op_e;

  state_e state_q, state_d;
  op_e op_q, op_d;
  logic [1:0] mode_q;
  ffha_pkg::addr_t addr_q, size_q, count_q, x_q, x_d;
  logic [63:0] prod_q;
  logic calloc_q, calloc_d;
  // Results of the scans; the right neighbour comes from the second scan.
  logic find_hit_q, fit_hit_q, empty_hit_q, left_hit_q, right_hit_q;
  ffha_pkg::idx_t s_idx_q, fit_idx_q, empty_idx_q, left_idx_q, right_idx_q;
  ffha_pkg::addr_t s_size_q, fit_start_q, left_size_q, right_size_q;
  // Result fields under construction.
  ffha_pkg::addr_t res_q, res_d, src_q, src_d, len_q, len_d, clr_q, clr_d;
  logic [2:0] st_q, st_d;
  // Pending single write and break update.
  ffha_pkg::cell_wr_t pw_q, pw_d;
  logic pw_brk_q, pw_brk_d;
  ffha_pkg::addr_t brk_next_q, brk_next_d;
  // Merge sequence controls.
  logic fseq_q, fseq_d, fl_q, fl_d, fr_q, fr_d, tfree_q, tfree_d;
  ffha_pkg::addr_t acc_q, acc_d;
  ffha_pkg::addr_t break_q, break_d;
  logic out_valid_q, out_valid_d;
  logic [127:0] out_data_q, out_data_d;
  logic [2:0] out_stat_q, out_stat_d;

  ffha_pkg::addr_t hdr32, extra_w, alloc_res;
  logic [ffha_pkg::ADDR_W:0] need_w, room_w, end_s;
  logic brk_le, need_ok, extra_ok, in_acc;
  logic [2:0] alloc_st;
  ffha_pkg::cell_wr_t alloc_pw;
  logic [63:0] mul_w;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc = in_valid_i && in_ready_o;
  assign mul_w = 64'(count_q) * 64'(size_q);

  // Break growth checks and the allocate outcome from the scan results.
  always_comb begin
    hdr32 = {{(ffha_pkg::ADDR_W - ffha_pkg::HDR_W){1'b0}}, hdr_i};
    need_w = {1'b0, x_q} + {1'b0, hdr32};
    room_w = {1'b0, limit_i} - {1'b0, break_q};
    brk_le = (break_q <= limit_i);
    need_ok = brk_le && (need_w <= room_w);
    extra_w = x_q - s_size_q;
    extra_ok = brk_le && ({1'b0, extra_w} <= room_w);
    end_s = {1'b0, addr_q} + {1'b0, s_size_q};
    if (fit_hit_q) begin
      alloc_st = ffha_pkg::STAT_OK;
    end else if (!need_ok) begin
      alloc_st = ffha_pkg::STAT_NO_HEAP;
    end else if (!empty_hit_q) begin
      alloc_st = ffha_pkg::STAT_FULL;
    end else begin
      alloc_st = ffha_pkg::STAT_OK;
    end
    alloc_pw = '0;
    alloc_pw.we = 1'b1;
    alloc_pw.used = 1'b1;
    alloc_pw.is_free = 1'b0;
    if (fit_hit_q) begin
      alloc_pw.idx = fit_idx_q;
    end else begin
      alloc_pw.idx = empty_idx_q;
      alloc_pw.start_we = 1'b1;
      alloc_pw.start = break_q;
      alloc_pw.size_we = 1'b1;
      alloc_pw.size = x_q;
    end
    alloc_res = fit_hit_q ? (fit_start_q + hdr32) : (break_q + hdr32);
  end

  // The first cell compares in the cycle the scan starts, so it sees the
  // request size before it is registered.
  assign query_o.addr = addr_q;
  assign query_o.fit_size = (state_q == S_DECIDE) ? x_d : x_q;
  assign query_o.hdr = hdr_i;
  assign query_o.end_s = end_s;

  // Main sequencer.
  always_comb begin
    state_d = state_q;
    op_d = op_q;
    x_d = x_q;
    calloc_d = calloc_q;
    res_d = res_q;
    src_d = src_q;
    len_d = len_q;
    clr_d = clr_q;
    st_d = st_q;
    pw_d = pw_q;
    pw_brk_d = pw_brk_q;
    brk_next_d = brk_next_q;
    fseq_d = fseq_q;
    fl_d = fl_q;
    fr_d = fr_q;
    tfree_d = tfree_q;
    acc_d = acc_q;
    break_d = base_load_i ? base_i : break_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d = out_data_q;
    out_stat_d = out_stat_q;
    start_o = 1'b0;
    wr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_DECIDE;
      end
      // Decode the mode and start the first scan where one is needed.
      S_DECIDE: begin
        res_d = '0;
        src_d = '0;
        len_d = '0;
        clr_d = '0;
        st_d = ffha_pkg::STAT_OK;
        pw_d = '0;
        pw_brk_d = 1'b0;
        fseq_d = 1'b0;
        calloc_d = 1'b0;
        x_d = size_q;
        state_d = S_PASSA;
        case (mode_q)
          ffha_pkg::MODE_ALLOC: begin
            op_d = OP_ALLOC;
            if (size_q == '0) begin
              st_d = ffha_pkg::STAT_NULL;
              state_d = S_DONE;
            end
          end
          ffha_pkg::MODE_FREE: begin
            op_d = OP_FREE;
            if (addr_q == '0) begin
              st_d = ffha_pkg::STAT_NULL;
              state_d = S_DONE;
            end
          end
          ffha_pkg::MODE_REALLOC: begin
            if (addr_q == '0) begin
              op_d = OP_ALLOC;
              if (size_q == '0) begin
                st_d = ffha_pkg::STAT_NULL;
                state_d = S_DONE;
              end
            end else if (size_q == '0) begin
              op_d = OP_FREE;
            end else begin
              op_d = OP_REALLOC;
            end
          end
          default: begin
            op_d = OP_ALLOC;
            calloc_d = 1'b1;
            x_d = prod_q[31:0];
            if ((count_q == '0) || (size_q == '0)) begin
              st_d = ffha_pkg::STAT_NULL;
              state_d = S_DONE;
            end else if (prod_q[63:32] != '0) begin
              st_d = ffha_pkg::STAT_OVERFLOW;
              state_d = S_DONE;
            end
          end
        endcase
        start_o = (state_d == S_PASSA);
      end
      S_PASSA: begin
        if (tail_i.valid) begin
          state_d = S_EVALA;
        end
      end
      // Decide on the first scan: allocate finishes here.
      S_EVALA: begin
        case (op_q)
          OP_ALLOC: begin
            st_d = alloc_st;
            if (alloc_st == ffha_pkg::STAT_OK) begin
              pw_d = alloc_pw;
              pw_brk_d = !fit_hit_q;
              brk_next_d = break_q + need_w[ffha_pkg::ADDR_W-1:0];
              res_d = alloc_res;
              if (calloc_q) begin
                clr_d = x_q;
              end
              state_d = S_WALLOC;
            end else begin
              state_d = S_DONE;
            end
          end
          OP_FREE: begin
            if (!find_hit_q) begin
              st_d = ffha_pkg::STAT_UNKNOWN;
              state_d = S_DONE;
            end else begin
              start_o = 1'b1;
              state_d = S_PASSB;
            end
          end
          default: begin
            if (!find_hit_q) begin
              st_d = ffha_pkg::STAT_UNKNOWN;
              state_d = S_DONE;
            end else if (s_size_q >= x_q) begin
              res_d = addr_q;
              state_d = S_DONE;
            end else begin
              start_o = 1'b1;
              state_d = S_PASSB;
            end
          end
        endcase
      end
      S_PASSB: begin
        if (tail_i.valid) begin
          state_d = S_EVALB;
        end
      end
      // Decide on the neighbour scan.
      S_EVALB: begin
        state_d = S_WALLOC;
        if (op_q == OP_FREE) begin
          fseq_d = 1'b1;
          fl_d = left_hit_q;
          fr_d = right_hit_q;
          tfree_d = 1'b1;
        end else if (right_hit_q && (right_size_q >= extra_w)) begin
          // Absorb the following free block.
          fseq_d = 1'b1;
          fl_d = 1'b0;
          fr_d = 1'b1;
          tfree_d = 1'b0;
          res_d = addr_q;
        end else if (end_s == {1'b0, break_q}) begin
          // Extend at the break.
          if (!extra_ok) begin
            st_d = ffha_pkg::STAT_NO_HEAP;
            state_d = S_DONE;
          end else begin
            pw_d = '0;
            pw_d.we = 1'b1;
            pw_d.idx = s_idx_q;
            pw_d.used = 1'b1;
            pw_d.size_we = 1'b1;
            pw_d.size = x_q;
            pw_brk_d = 1'b1;
            brk_next_d = break_q + extra_w;
            res_d = addr_q;
          end
        end else begin
          // Move: allocate anew, then free the old block.
          st_d = alloc_st;
          if (alloc_st == ffha_pkg::STAT_OK) begin
            pw_d = alloc_pw;
            pw_brk_d = !fit_hit_q;
            brk_next_d = break_q + need_w[ffha_pkg::ADDR_W-1:0];
            res_d = alloc_res;
            src_d = addr_q;
            len_d = s_size_q;
            fseq_d = 1'b1;
            fl_d = left_hit_q && !(fit_hit_q && (left_idx_q == fit_idx_q));
            fr_d = right_hit_q && !(fit_hit_q && (right_idx_q == fit_idx_q));
            tfree_d = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_WALLOC: begin
        wr_o = pw_q;
        if (pw_q.we && pw_brk_q) begin
          break_d = brk_next_q;
        end
        state_d = fseq_q ? S_SUM1 : S_DONE;
      end
      // Merged size is summed in S_SUM1 and then S_SUM2.
      S_SUM1: begin
        acc_d = s_size_q + (fl_q ? (left_size_q + hdr32) : '0);
        state_d = S_SUM2;
      end
      S_SUM2: begin
        acc_d = acc_q + (fr_q ? (right_size_q + hdr32) : '0);
        state_d = S_WT;
      end
      S_WT: begin
        wr_o.we = 1'b1;
        wr_o.idx = fl_q ? left_idx_q : s_idx_q;
        wr_o.used = 1'b1;
        wr_o.is_free = tfree_q;
        wr_o.size_we = 1'b1;
        wr_o.size = acc_q;
        state_d = S_WS;
      end
      S_WS: begin
        wr_o.we = fl_q;
        wr_o.idx = s_idx_q;
        state_d = S_WR;
      end
      S_WR: begin
        wr_o.we = fr_q;
        wr_o.idx = right_idx_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d = {clr_q, len_q, src_q, res_q};
          out_stat_d = st_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      break_q <= ffha_pkg::BASE_RESET;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      break_q <= break_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_mode_i;
      addr_q <= in_addr_i;
      size_q <= in_size_i;
      count_q <= in_count_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= mul_w;
    end
    if ((state_q == S_PASSA) && tail_i.valid) begin
      find_hit_q <= tail_i.find_hit;
      s_idx_q <= tail_i.find_idx;
      s_size_q <= tail_i.find_size;
      fit_hit_q <= tail_i.fit_hit;
      fit_idx_q <= tail_i.fit_idx;
      fit_start_q <= tail_i.fit_start;
      empty_hit_q <= tail_i.empty_hit;
      empty_idx_q <= tail_i.empty_idx;
      left_hit_q <= tail_i.left_hit;
      left_idx_q <= tail_i.left_idx;
      left_size_q <= tail_i.left_size;
    end
    if ((state_q == S_PASSB) && tail_i.valid) begin
      right_hit_q <= tail_i.right_hit;
      right_idx_q <= tail_i.right_idx;
      right_size_q <= tail_i.right_size;
    end
    op_q <= op_d;
    x_q <= x_d;
    calloc_q <= calloc_d;
    res_q <= res_d;
    src_q <= src_d;
    len_q <= len_d;
    clr_q <= clr_d;
    st_q <= st_d;
    pw_q <= pw_d;
    pw_brk_q <= pw_brk_d;
    brk_next_q <= brk_next_d;
    fseq_q <= fseq_d;
    fl_q <= fl_d;
    fr_q <= fr_d;
    tfree_q <= tfree_d;
    acc_q <= acc_d;
    out_data_q <= out_data_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;
  assign out_status_o = out_stat_q;

`ifndef SYNTHESIS
  // The break only grows, except when a base write reloads it.
  a_break_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !base_load_i |=> (break_q >= $past(break_q)))
    else $error("break pointer moved backwards");

  // A scan word leaves the row only while a scan is awaited.
  a_tail_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_i.valid |-> ((state_q == S_PASSA) || (state_q == S_PASSB)))
    else $error("scan word arrived outside a scan");

  // Slot writes happen only in the write steps.
  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> ((state_q == S_WALLOC) || (state_q == S_WT) || (state_q == S_WS)
                 || (state_q == S_WR)))
    else $error("slot write outside a write step");

  // A new result word follows completion of a request.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result word without a finished request");

  // A new scan never overlaps one still in the row.
  a_one_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_o |-> !tail_i.valid)
    else $error("scan started while another completes");
`endif

endmodule

[sv/first_fit_heap_allocator.sv]
// First-fit heap allocator. The block table lives in a row of MAX_BLOCKS
// cells; each request that looks at the table sends a scan word down the
// row, one cell per cycle. Allocate and zeroed allocate need one scan; free
// and a growing reallocate need a second scan for the neighbours. Null,
// overflow and unknown-block answers are quicker. One request is worked on
// at a time; the next word is taken while the previous result waits in the
// output register. Slot flags clear at reset, so no clearing pass is needed.
// Configure only while idle.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: block_address [31:0], request_size [63:32], item_count [95:64]
  input  logic [95:0]  s_axis_tdata,
  // tuser: mode [1:0]
  input  logic [1:0]   s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: result_address [31:0], copy_source [63:32], copy_length [95:64],
  //        clear_length [127:96]
  output logic [127:0] m_axis_tdata,
  // tuser: status [2:0]
  output logic [2:0]   m_axis_tuser,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  ffha_pkg::addr_t base_q, limit_q;
  logic [ffha_pkg::HDR_W-1:0] hdr_q;
  logic cfg_wr, any_used, base_load;
  logic [MAX_BLOCKS-1:0] used_w;
  ffha_pkg::scan_word_t chain [MAX_BLOCKS+1];
  ffha_pkg::scan_query_t query;
  ffha_pkg::cell_wr_t wr;
  logic scan_start;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign any_used = |used_w;
  assign base_load = cfg_wr && (paddr[3:2] == ffha_pkg::REG_BASE) && !any_used;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ffha_pkg::BASE_RESET;
      limit_q <= ffha_pkg::LIMIT_RESET;
      hdr_q <= ffha_pkg::HDR_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ffha_pkg::REG_BASE:  base_q <= pwdata;
        ffha_pkg::REG_LIMIT: limit_q <= pwdata;
        ffha_pkg::REG_HDR:   hdr_q <= pwdata[ffha_pkg::HDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      ffha_pkg::REG_BASE:  prdata = base_q;
      ffha_pkg::REG_LIMIT: prdata = limit_q;
      ffha_pkg::REG_HDR:   prdata = {{(32 - ffha_pkg::HDR_W){1'b0}}, hdr_q};
      default:             prdata = '0;
    endcase
  end

  // The scan word enters the first cell empty.
  always_comb begin
    chain[0] = '0;
    chain[0].valid = scan_start;
  end

  // Row of table cells.
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffha_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .query_i (query),
      .wr_i    (wr),
      .word_i  (chain[g]),
      .word_o  (chain[g+1]),
      .used_o  (used_w[g])
    );
  end

  ffha_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (s_axis_tuser),
    .in_addr_i    (s_axis_tdata[31:0]),
    .in_size_i    (s_axis_tdata[63:32]),
    .in_count_i   (s_axis_tdata[95:64]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .hdr_i        (hdr_q),
    .limit_i      (limit_q),
    .base_load_i  (base_load),
    .base_i       (pwdata),
    .query_o      (query),
    .start_o      (scan_start),
    .tail_i       (chain[MAX_BLOCKS]),
    .wr_o         (wr)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the first-fit heap allocator.
// Drives request words and configuration writes, and checks every result word
// against a behavioural allocator model. Depends on ffha_pkg and the allocator.
`timescale 1ns / 100ps

module testbench;

  // Result word as the allocator reports it.
  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  st;
    logic [31:0] src;
    logic [31:0] len;
    logic [31:0] clr;
  } grant_t;

  // One row of the directed stimulus.
  typedef struct {
    logic [1:0]  mode;
    logic [31:0] addr;
    logic [31:0] size;
    logic [31:0] count;
    bit          fixed;
    logic [31:0] e_addr;
    logic [2:0]  e_st;
  } row_t;

  localparam int NBLK = 64;
  localparam int SETTLE = 300;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         psel, penable, pwrite, pready;
  logic [3:0]   paddr;
  logic [31:0]  pwdata, prdata;

  // Model of the block table, break pointer and registers.
  logic [63:0] blk_start [NBLK];
  logic [63:0] blk_size [NBLK];
  bit          blk_free [NBLK];
  bit          blk_used [NBLK];
  logic [63:0] brk, cfg_base, cfg_limit, cfg_hdr;

  grant_t pending_grants[$];
  int     errors = 0;
  int     n_checked = 0;
  int     n_sent = 0;
  int     snd_idle = 34;
  int     rcv_idle = 53;
  bit     hold_req = 1'b0;
  int     hold_left = 0;

  first_fit_heap_allocator dut (.*);

  always #4 clk_i = ~clk_i;

  // Abandon the run if it hangs.
  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] end_of(int i);
    return blk_start[i] + cfg_hdr + blk_size[i];
  endfunction

  function automatic bit grow_ok(logic [63:0] amount);
    return brk <= cfg_limit && amount <= cfg_limit - brk;
  endfunction

  function automatic int find_live(logic [63:0] a);
    for (int i = 0; i < NBLK; i++)
      if (blk_used[i] && !blk_free[i] && blk_start[i] + cfg_hdr == a) return i;
    return -1;
  endfunction

  function automatic void merge(int lo, int hi);
    blk_size[lo] += blk_size[hi] + cfg_hdr;
    blk_used[hi] = 1'b0;
    blk_free[hi] = 1'b0;
  endfunction

  // Merge a freshly freed block with a free block below, then above.
  function automatic void join_free(int s);
    for (int i = 0; i < NBLK; i++)
      if (i != s && blk_used[i] && blk_free[i] && end_of(i) == blk_start[s]) begin
        merge(i, s);
        s = i;
        break;
      end
    for (int i = 0; i < NBLK; i++)
      if (i != s && blk_used[i] && blk_free[i] && blk_start[i] == end_of(s)) begin
        merge(s, i);
        break;
      end
  endfunction

  function automatic logic [2:0] take_block(logic [63:0] sz, output logic [63:0] ra);
    int best;
    int slot;
    best = -1;
    slot = -1;
    ra = 0;
    if (sz == 0) return ffha_pkg::STAT_NULL;
    for (int i = 0; i < NBLK; i++)
      if (blk_used[i] && blk_free[i] && blk_size[i] >= sz &&
          (best < 0 || blk_start[i] < blk_start[best])) best = i;
    if (best >= 0) begin
      blk_free[best] = 1'b0;
      ra = blk_start[best] + cfg_hdr;
      return ffha_pkg::STAT_OK;
    end
    if (!grow_ok(cfg_hdr + sz)) return ffha_pkg::STAT_NO_HEAP;
    for (int i = 0; i < NBLK; i++)
      if (!blk_used[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) return ffha_pkg::STAT_FULL;
    blk_used[slot] = 1'b1;
    blk_free[slot] = 1'b0;
    blk_start[slot] = brk;
    blk_size[slot] = sz;
    brk += cfg_hdr + sz;
    ra = blk_start[slot] + cfg_hdr;
    return ffha_pkg::STAT_OK;
  endfunction

  function automatic logic [2:0] release_block(logic [63:0] a);
    int s;
    if (a == 0) return ffha_pkg::STAT_NULL;
    s = find_live(a);
    if (s < 0) return ffha_pkg::STAT_UNKNOWN;
    blk_free[s] = 1'b1;
    join_free(s);
    return ffha_pkg::STAT_OK;
  endfunction

  // Keep, absorb a free neighbour, extend at the break, or move.
  function automatic logic [2:0] resize_block(logic [63:0] a, logic [63:0] sz,
                                              output logic [63:0] ra,
                                              inout logic [63:0] src, len);
    int s;
    logic [63:0] old_end, extra, old_sz, na;
    logic [2:0] st;
    ra = 0;
    if (a == 0) return take_block(sz, ra);
    if (sz == 0) return release_block(a);
    s = find_live(a);
    if (s < 0) return ffha_pkg::STAT_UNKNOWN;
    if (blk_size[s] >= sz) begin
      ra = a;
      return ffha_pkg::STAT_OK;
    end
    old_end = end_of(s);
    extra = sz - blk_size[s];
    for (int i = 0; i < NBLK; i++)
      if (i != s && blk_used[i] && blk_free[i] && blk_start[i] == old_end &&
          blk_size[i] >= extra) begin
        merge(s, i);
        ra = a;
        return ffha_pkg::STAT_OK;
      end
    if (old_end == brk) begin
      if (!grow_ok(extra)) return ffha_pkg::STAT_NO_HEAP;
      brk += extra;
      blk_size[s] = sz;
      ra = a;
      return ffha_pkg::STAT_OK;
    end
    old_sz = blk_size[s];
    st = take_block(sz, na);
    if (st != ffha_pkg::STAT_OK) return st;
    src = a;
    len = (old_sz < sz) ? old_sz : sz;
    void'(release_block(a));
    ra = na;
    return ffha_pkg::STAT_OK;
  endfunction

  function automatic grant_t predict_grant(logic [1:0] m, logic [63:0] a, sz, cnt);
    grant_t g;
    logic [63:0] ra, src, len, tot;
    g = '0;
    ra = 0;
    src = 0;
    len = 0;
    case (m)
      ffha_pkg::MODE_ALLOC: g.st = take_block(sz, ra);
      ffha_pkg::MODE_FREE: g.st = release_block(a);
      ffha_pkg::MODE_REALLOC: g.st = resize_block(a, sz, ra, src, len);
      default: begin
        if (cnt == 0 || sz == 0) begin
          g.st = ffha_pkg::STAT_NULL;
        end else begin
          tot = cnt * sz;
          if (tot > 64'hFFFF_FFFF) begin
            g.st = ffha_pkg::STAT_OVERFLOW;
          end else begin
            g.st = take_block(tot, ra);
            if (g.st == ffha_pkg::STAT_OK) g.clr = tot[31:0];
          end
        end
      end
    endcase
    g.addr = ra[31:0];
    g.src = src[31:0];
    g.len = len[31:0];
    return g;
  endfunction

  function automatic logic [31:0] pick_live();
    int idx[$];
    int k;
    for (int i = 0; i < NBLK; i++)
      if (blk_used[i] && !blk_free[i]) idx.push_back(i);
    if (idx.size() == 0) return 32'd0;
    k = idx[$urandom_range(idx.size() - 1)];
    return 32'(blk_start[k] + cfg_hdr);
  endfunction

  // Offer one request word and record what it should produce.
  task automatic send_req(logic [1:0] m, logic [31:0] a, sz, cnt,
                          bit fixed = 1'b0, grant_t fx = '0);
    grant_t g;
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {cnt, sz, a};
    s_axis_tuser <= m;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    g = predict_grant(m, a, sz, cnt);
    pending_grants.push_back(fixed ? fx : g);
    n_sent++;
  endtask

  // Stop offering words and wait until every result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending_grants.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    int i;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      ffha_pkg::REG_BASE: begin
        cfg_base = val;
        i = 0;
        foreach (blk_used[j]) if (blk_used[j]) i++;
        if (i == 0) brk = cfg_base;
      end
      ffha_pkg::REG_LIMIT: cfg_limit = val;
      default: cfg_hdr = val & 32'h7F;
    endcase
  endtask

  task automatic random_req();
    int r;
    logic [31:0] a;
    r = $urandom_range(99);
    if (r < 40) begin
      send_req(ffha_pkg::MODE_ALLOC, $urandom, ($urandom_range(19) == 0) ? $urandom :
               $urandom_range(1, 300), $urandom);
    end else if (r < 58) begin
      a = pick_live();
      send_req(ffha_pkg::MODE_FREE, (a == 0) ? $urandom : a, $urandom, $urandom);
    end else if (r < 78) begin
      a = ($urandom_range(9) == 0) ? 32'd0 : pick_live();
      send_req(ffha_pkg::MODE_REALLOC, a, $urandom_range(0, 400), $urandom);
    end else if (r < 88) begin
      send_req(ffha_pkg::MODE_CALLOC, $urandom, $urandom_range(1, 32),
               $urandom_range(1, 16));
    end else begin
      send_req(2'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  // Check each result word against the oldest expectation.
  always @(posedge clk_i) begin
    grant_t exp_g, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[63:32],
             m_axis_tdata[95:64], m_axis_tdata[127:96]};
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word: %p", got);
      end else begin
        exp_g = pending_grants.pop_front();
        n_checked++;
        if (got !== exp_g) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch on result %0d: expected %p, got %p", n_checked, exp_g, got);
        end
      end
    end
  end

  // Result side: random back-pressure, plus a long hold on request.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    row_t rows[$];
    int k;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ffha_pkg::MODE_ALLOC;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_base = ffha_pkg::BASE_RESET;
    cfg_limit = ffha_pkg::LIMIT_RESET;
    cfg_hdr = ffha_pkg::HDR_RESET;
    brk = ffha_pkg::BASE_RESET;
    foreach (blk_used[i]) begin
      blk_used[i] = 1'b0;
      blk_free[i] = 1'b0;
      blk_start[i] = 0;
      blk_size[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: null and unknown requests, overflow, reuse and resizing.
    rows = '{
      '{ffha_pkg::MODE_ALLOC, 32'h0, 32'h0, 32'h0, 1, 32'h0, ffha_pkg::STAT_NULL},
      '{ffha_pkg::MODE_FREE, 32'h0, 32'h5, 32'h0, 1, 32'h0, ffha_pkg::STAT_NULL},
      '{ffha_pkg::MODE_FREE, 32'h1234, 32'h0, 32'h0, 1, 32'h0, ffha_pkg::STAT_UNKNOWN},
      '{ffha_pkg::MODE_REALLOC, 32'h1234, 32'h8, 32'h0, 1, 32'h0,
        ffha_pkg::STAT_UNKNOWN},
      '{ffha_pkg::MODE_CALLOC, 32'h0, 32'h4, 32'h0, 1, 32'h0, ffha_pkg::STAT_NULL},
      '{ffha_pkg::MODE_CALLOC, 32'h0, 32'h0, 32'h9, 1, 32'h0, ffha_pkg::STAT_NULL},
      '{ffha_pkg::MODE_CALLOC, 32'h0, 32'h1_0000, 32'h1_0000, 1, 32'h0,
        ffha_pkg::STAT_OVERFLOW},
      '{ffha_pkg::MODE_ALLOC, 32'h0, 32'd100, 32'h0, 1, 32'd4112, ffha_pkg::STAT_OK},
      '{ffha_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0,
        ffha_pkg::STAT_NO_HEAP},
      '{ffha_pkg::MODE_CALLOC, 32'h0, 32'd5, 32'd3, 0, 32'h0, ffha_pkg::STAT_OK},
      '{ffha_pkg::MODE_ALLOC, 32'h0, 32'd40, 32'h0, 0, 32'h0, ffha_pkg::STAT_OK},
      '{ffha_pkg::MODE_FREE, 32'd4112, 32'h0, 32'h0, 0, 32'h0, ffha_pkg::STAT_OK},
      '{ffha_pkg::MODE_FREE, 32'd4112, 32'h0, 32'h0, 1, 32'h0, ffha_pkg::STAT_UNKNOWN},
      '{ffha_pkg::MODE_ALLOC, 32'h0, 32'd50, 32'h0, 0, 32'h0, ffha_pkg::STAT_OK},
      '{ffha_pkg::MODE_REALLOC, 32'd4112, 32'd90, 32'h0, 0, 32'h0, ffha_pkg::STAT_OK},
      '{ffha_pkg::MODE_REALLOC, 32'd4112, 32'd300, 32'h0, 0, 32'h0, ffha_pkg::STAT_OK},
      '{ffha_pkg::MODE_REALLOC, 32'h0, 32'd10, 32'h0, 0, 32'h0, ffha_pkg::STAT_OK},
      '{ffha_pkg::MODE_REALLOC, 32'h0, 32'h0, 32'h0, 1, 32'h0, ffha_pkg::STAT_NULL},
      '{ffha_pkg::MODE_CALLOC, 32'h0, 32'h1, 32'hFFFF_FFFF, 0, 32'h0, ffha_pkg::STAT_OK},
      '{ffha_pkg::MODE_CALLOC, 32'h0, 32'hFFFF_FFFF, 32'h2, 1, 32'h0,
        ffha_pkg::STAT_OVERFLOW},
      '{ffha_pkg::MODE_ALLOC, 32'h0, 32'd20, 32'h0, 0, 32'h0, ffha_pkg::STAT_OK}
    };
    foreach (rows[i]) begin
      grant_t fx;
      fx = '0;
      fx.addr = rows[i].e_addr;
      fx.st = rows[i].e_st;
      send_req(rows[i].mode, rows[i].addr, rows[i].size, rows[i].count, rows[i].fixed, fx);
    end
    // The moving resize and size-zero resize of a live block.
    send_req(ffha_pkg::MODE_REALLOC, pick_live(), 32'd2000, 32'h0);
    send_req(ffha_pkg::MODE_REALLOC, pick_live(), 32'h0, 32'h0);

    // Random part in four register settings, with extremes of the base and limit registers.
    k = 0;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          reg_write(ffha_pkg::REG_BASE, 32'hFFFF_FFFF);
          reg_write(ffha_pkg::REG_HDR, 32'd8);
          reg_write(ffha_pkg::REG_LIMIT, 32'(brk + 3000));
        end
        1: begin
          reg_write(ffha_pkg::REG_LIMIT, 32'hFFFF_FFFF);
          reg_write(ffha_pkg::REG_HDR, 32'd64);
        end
        2: begin
          reg_write(ffha_pkg::REG_BASE, 32'h0);
          reg_write(ffha_pkg::REG_HDR, 32'd40);
          reg_write(ffha_pkg::REG_LIMIT, 32'h0);
        end
        default: begin
          reg_write(ffha_pkg::REG_LIMIT, 32'(brk + 20000));
          reg_write(ffha_pkg::REG_HDR, 32'd16);
        end
      endcase
      // Burst of small allocations against a stalled receiver fills the table.
      hold_req = 1'b1;
      for (int i = 0; i < 70; i++, k++)
        send_req(ffha_pkg::MODE_ALLOC, $urandom, $urandom_range(1, 64), 0);
      drain();
      for (int i = 0; i < 310; i++, k++) begin
        if (k < 517) begin
          snd_idle = 34;
          rcv_idle = 53;
        end else if (k < 1034) begin
          snd_idle = 53;
          rcv_idle = 34;
        end else begin
          snd_idle = 0;
          rcv_idle = 0;
        end
        random_req();
      end
    end
    drain();

    $display("Sent %0d requests over four register settings; %0d results compared.",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
